/* rtl/core/sfp_pkg.sv */
`timescale 1ns / 1ps
package sfp_pkg;
  localparam int unsigned WarmupRounds = 20;
  localparam int unsigned RoundW = $clog2(WarmupRounds + 1);

  localparam logic [1:0] OP_SEED  = 2'd0;
  localparam logic [1:0] OP_RAW   = 2'd1;
  localparam logic [1:0] OP_RANGE = 2'd2;

  localparam logic [1:0] SEL_8  = 2'd0;
  localparam logic [1:0] SEL_16 = 2'd1;
  localparam logic [1:0] SEL_32 = 2'd2;
  localparam logic [1:0] SEL_64 = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  width_sel;
    logic [63:0] seed_value;
    logic [63:0] range_low;
    logic [63:0] range_high;
  } sfp_cmd_t;

  typedef struct packed {
    logic [63:0] value;
    logic        range_error;
  } sfp_res_t;

  typedef logic [3:0][63:0] sfp_words_t;

  function automatic logic [63:0] width_mask(input logic [1:0] sel);
    logic [63:0] m;
    case (sel)
      SEL_8:   m = 64'h0000_0000_0000_00ff;
      SEL_16:  m = 64'h0000_0000_0000_ffff;
      SEL_32:  m = 64'h0000_0000_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

  // One generator round; words are a, b, c, d in slots 0..3.
  function automatic sfp_words_t jsf_round(input sfp_words_t s, input logic [1:0] sel);
    sfp_words_t n;
    logic [63:0] e;
    n = s;
    case (sel)
      SEL_8: begin
        e = {56'd0, s[0][7:0] - {s[1][6:0], s[1][7]}};
        n[0] = {56'd0, s[1][7:0] ^ {s[2][3:0], s[2][7:4]}};
        n[1] = {56'd0, s[2][7:0] + s[3][7:0]};
        n[2] = {56'd0, s[3][7:0] + e[7:0]};
        n[3] = {56'd0, e[7:0] + n[0][7:0]};
      end
      SEL_16: begin
        e = {48'd0, s[0][15:0] - {s[1][2:0], s[1][15:3]}};
        n[0] = {48'd0, s[1][15:0] ^ {s[2][7:0], s[2][15:8]}};
        n[1] = {48'd0, s[2][15:0] + s[3][15:0]};
        n[2] = {48'd0, s[3][15:0] + e[15:0]};
        n[3] = {48'd0, e[15:0] + n[0][15:0]};
      end
      SEL_32: begin
        e = {32'd0, s[0][31:0] - {s[1][4:0], s[1][31:5]}};
        n[0] = {32'd0, s[1][31:0] ^ {s[2][14:0], s[2][31:15]}};
        n[1] = {32'd0, s[2][31:0] + s[3][31:0]};
        n[2] = {32'd0, s[3][31:0] + e[31:0]};
        n[3] = {32'd0, e[31:0] + n[0][31:0]};
      end
      default: begin
        e = s[0] - {s[1][24:0], s[1][63:25]};
        n[0] = s[1] ^ {s[2][52:0], s[2][63:53]};
        n[1] = s[2] + s[3];
        n[2] = s[3] + e;
        n[3] = e + n[0];
      end
    endcase
    return n;
  endfunction
endpackage

/* rtl/core/sfp_if.sv */
`timescale 1ns / 1ps
interface sfp_cmd_if;
  logic valid;
  logic ready;
  sfp_pkg::sfp_cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sfp_res_if;
  logic valid;
  logic ready;
  sfp_pkg::sfp_res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/sfp_queue.sv */
`timescale 1ns / 1ps
module sfp_queue (
  input  logic clk,
  input  logic rst_n,
  sfp_cmd_if.sink   enq,
  sfp_cmd_if.source deq
);
  import sfp_pkg::*;
  sfp_cmd_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign enq.ready = (cnt_r != 2'd2);
  assign deq.valid = (cnt_r != 2'd0);
  assign deq.data  = mem_r[rp_r];
  assign push = enq.valid && enq.ready;
  assign pop  = deq.valid && deq.ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= enq.data;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* rtl/core/sfp_engine.sv */
`timescale 1ns / 1ps
module sfp_engine (
  input  logic clk,
  input  logic rst_n,
  sfp_cmd_if.sink   cmd,
  sfp_res_if.source res
);
  import sfp_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SEED  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;

  logic [2:0]  state_r, state_nxt;
  sfp_words_t  g_r [4];
  logic [RoundW-1:0] rnd_r;
  logic [1:0]  sel_r;
  logic [63:0] lo_r, span_r, num_r, rem_r;
  logic [6:0]  bit_r;
  sfp_res_t    out_r;
  logic        out_v_r;

  sfp_words_t  drawn;
  logic [63:0] m, lo_m, hi_m;
  logic [64:0] rem_sh;
  logic [64:0] rem_sub;

  assign m    = width_mask(cmd.data.width_sel);
  assign lo_m = cmd.data.range_low & m;
  assign hi_m = cmd.data.range_high & m;
  assign drawn = jsf_round(g_r[cmd.data.width_sel], cmd.data.width_sel);

  assign cmd.ready = (state_r == ST_IDLE) && !out_v_r;
  assign res.valid = out_v_r;
  assign res.data  = out_r;

  assign rem_sh  = {rem_r, num_r[bit_r[5:0]]};
  assign rem_sub = rem_sh - {1'b0, span_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (cmd.valid && cmd.ready) begin
        case (cmd.data.opcode)
          OP_SEED:  state_nxt = ST_SEED;
          OP_RANGE: state_nxt = (hi_m > lo_m) ? ST_MOD : ST_IDLE;
          default:  state_nxt = ST_IDLE;
        endcase
      end
      ST_SEED: if (rnd_r == RoundW'(WarmupRounds)) state_nxt = ST_IDLE;
      ST_MOD:  if (bit_r == 7'd0) state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_v_r <= 1'b0;
      rnd_r <= '0;
      for (int i = 0; i < 4; i++) g_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (res.valid && res.ready) out_v_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (cmd.valid && cmd.ready) begin
          sel_r <= cmd.data.width_sel;
          case (cmd.data.opcode)
            OP_SEED: begin
              g_r[0] <= {{3{56'd0, cmd.data.seed_value[7:0]}}, 64'h00ed};
              g_r[1] <= {{3{48'd0, cmd.data.seed_value[15:0]}}, 64'h5eed};
              g_r[2] <= {{3{32'd0, cmd.data.seed_value[31:0]}}, 64'hf1ea5eed};
              g_r[3] <= {{3{cmd.data.seed_value}}, 64'hf1ea5eed};
              rnd_r <= '0;
            end
            OP_RAW: begin
              g_r[cmd.data.width_sel] <= drawn;
              out_r <= '{value: drawn[3], range_error: 1'b0};
              out_v_r <= 1'b1;
            end
            OP_RANGE: begin
              g_r[cmd.data.width_sel] <= drawn;
              if (hi_m > lo_m) begin
                span_r <= hi_m - lo_m;
                lo_r <= lo_m;
                num_r <= drawn[3];
                rem_r <= '0;
                case (cmd.data.width_sel)
                  SEL_8:   bit_r <= 7'd7;
                  SEL_16:  bit_r <= 7'd15;
                  SEL_32:  bit_r <= 7'd31;
                  default: bit_r <= 7'd63;
                endcase
              end else begin
                out_r <= '{value: 64'd0, range_error: 1'b1};
                out_v_r <= 1'b1;
              end
            end
            default: begin
              out_r <= '{value: 64'd0, range_error: 1'b0};
              out_v_r <= 1'b1;
            end
          endcase
        end
        ST_SEED: begin
          // All four generators warm up together, one round per cycle.
          if (rnd_r == RoundW'(WarmupRounds)) begin
            out_r <= '{value: 64'd0, range_error: 1'b0};
            out_v_r <= 1'b1;
          end else begin
            for (int i = 0; i < 4; i++) g_r[i] <= jsf_round(g_r[i], 2'(i));
            rnd_r <= rnd_r + 1'b1;
          end
        end
        ST_MOD: begin
          // Restoring remainder, one numerator bit per cycle.
          if (!rem_sub[64]) rem_r <= rem_sub[63:0];
          else rem_r <= rem_sh[63:0];
          bit_r <= bit_r - 7'd1;
        end
        ST_ADD: begin
          out_r <= '{value: (rem_r + lo_r) & width_mask(sel_r), range_error: 1'b0};
          out_v_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

/* rtl/core/small_fast_prng_multiwidth_top.sv */
`timescale 1ns / 1ps
// Four small-fast generators of 8, 16, 32 and 64 bits.
// The in_ channel takes command beats (opcode, width_sel, seed_value,
// range_low, range_high); the out_ channel returns one beat per command
// with value and range_error. Both use valid/ready.
// A two-entry queue sits after the input, so commands can be taken while
// the engine works. The engine handles one command at a time.
// A seed runs 20 warm-up rounds, all four generators in parallel. A range
// draw runs a restoring remainder one bit per cycle over the generator
// width. The engine takes its next command only after the result has
// been taken, so it starts no new command while a result waits.
// A range draw with high not above low returns 0 with range_error set.
// Reset clears all generator state to zero and empties the queue.
// While the receiver stalls, the result holds and the engine waits; the
// queue keeps taking commands until it is full.
module small_fast_prng_multiwidth_top (
  input logic clk,
  input logic rst_n,
  sfp_cmd_if.sink   in_cmd,
  sfp_res_if.source out_res
);
  import sfp_pkg::*;
  sfp_cmd_if q_cmd ();

  sfp_queue u_queue (.clk(clk), .rst_n(rst_n), .enq(in_cmd), .deq(q_cmd));
  sfp_engine u_engine (.clk(clk), .rst_n(rst_n), .cmd(q_cmd), .res(out_res));
endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import sfp_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef logic [3:0][63:0] gen_bank_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sfp_cmd_if cmd_bus ();
  sfp_res_if res_bus ();

  small_fast_prng_multiwidth_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_cmd(cmd_bus.sink),
    .out_res(res_bus.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: one bank of words a, b, c, d per generator width.
  gen_bank_t gen_state [4];
  sfp_cmd_t cmd_queue [$];
  sfp_res_t expected_res [$];
  int unsigned send_idle_pct = 9;
  int unsigned recv_idle_pct = 49;
  int unsigned hold_off_cycles = 0;
  bit hold_off_req = 1'b0;
  bit drain_wait = 1'b0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned range_errors = 0;
  int unsigned cmds_sent = 0;
  int unsigned idle_cycles = 0;

  function automatic logic [63:0] mask_for(logic [1:0] sel);
    return (sel == SEL_64) ? '1 : ((64'd1 << (8 << sel)) - 64'd1);
  endfunction

  function automatic logic [63:0] rotl_for(logic [63:0] x, int unsigned k, logic [1:0] sel);
    int unsigned w;
    logic [63:0] m;
    w = 8 << sel;
    m = mask_for(sel);
    x = x & m;
    return ((x << k) | (x >> (w - k))) & m;
  endfunction

  function automatic logic [63:0] advance_gen(logic [1:0] sel);
    int unsigned r1;
    int unsigned r2;
    logic [63:0] m;
    logic [63:0] e;
    gen_bank_t s;
    s = gen_state[sel];
    m = mask_for(sel);
    case (sel)
      SEL_8: begin r1 = 1; r2 = 4; end
      SEL_16: begin r1 = 13; r2 = 8; end
      SEL_32: begin r1 = 27; r2 = 17; end
      default: begin r1 = 39; r2 = 11; end
    endcase
    e = (s[0] - rotl_for(s[1], r1, sel)) & m;
    s[0] = (s[1] ^ rotl_for(s[2], r2, sel)) & m;
    s[1] = (s[2] + s[3]) & m;
    s[2] = (s[3] + e) & m;
    s[3] = (e + s[0]) & m;
    gen_state[sel] = s;
    return s[3];
  endfunction

  function automatic sfp_res_t predict_draw(sfp_cmd_t c);
    sfp_res_t r;
    logic [63:0] m;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] d;
    logic [1:0] g;
    r = '0;
    case (c.opcode)
      OP_SEED: begin
        for (int i = 0; i < 4; i++) begin
          g = i[1:0];
          m = mask_for(g);
          gen_state[g][0] = ((g == SEL_8) ? 64'hed : (g == SEL_16) ? 64'h5eed
                             : 64'hf1ea5eed) & m;
          for (int j = 1; j < 4; j++) gen_state[g][j] = c.seed_value & m;
          for (int k = 0; k < WarmupRounds; k++) void'(advance_gen(g));
        end
      end
      OP_RAW: r.value = advance_gen(c.width_sel);
      OP_RANGE: begin
        m = mask_for(c.width_sel);
        lo = c.range_low & m;
        hi = c.range_high & m;
        d = advance_gen(c.width_sel);
        if (hi > lo) r.value = ((d % (hi - lo)) + lo) & m;
        else r.range_error = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic sfp_cmd_t make_cmd(logic [1:0] op, logic [1:0] sel, logic [63:0] seed,
                                        logic [63:0] lo, logic [63:0] hi);
    sfp_cmd_t c;
    c.opcode = op;
    c.width_sel = sel;
    c.seed_value = seed;
    c.range_low = lo;
    c.range_high = hi;
    return c;
  endfunction

  function automatic sfp_cmd_t random_cmd();
    int unsigned pick;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [1:0] sel;
    pick = $urandom_range(99);
    sel = 2'($urandom_range(3));
    lo = rand64();
    hi = rand64();
    // Mostly narrow spans and high above low, so the remainder path gets work.
    case ($urandom_range(5))
      0: lo = lo >> $urandom_range(63);
      1: hi = lo + $urandom_range(300);
      2: begin lo = lo >> $urandom_range(63); hi = hi >> $urandom_range(63); end
      default: begin
        lo = lo & mask_for(sel) >> 1;
        hi = lo + (hi & mask_for(sel) >> $urandom_range(1, 63)) + 1;
      end
    endcase
    if (pick < 3) return make_cmd(OP_SEED, sel, rand64(), lo, hi);
    if (pick < 5) return make_cmd(OP_UNUSED, sel, rand64(), lo, hi);
    if (pick < 45) return make_cmd(OP_RAW, sel, rand64(), lo, hi);
    return make_cmd(OP_RANGE, sel, rand64(), lo, hi);
  endfunction

  // Driver: offers the head of the pending queue, idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_bus.valid <= 1'b0;
      cmd_bus.data <= '0;
    end else if (cmd_bus.valid && !cmd_bus.ready) begin
      // Hold the beat until it is taken.
    end else begin
      if (cmd_bus.valid) begin
        expected_res.push_back(predict_draw(cmd_bus.data));
        cmds_sent++;
      end
      if (cmd_queue.size() > 0 && !drain_wait && $urandom_range(99) >= send_idle_pct) begin
        cmd_bus.valid <= 1'b1;
        cmd_bus.data <= cmd_queue.pop_front();
      end else begin
        cmd_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver ready, with a long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
      hold_off_cycles <= 0;
    end else if (hold_off_req && hold_off_cycles < 400) begin
      res_bus.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles + 1;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
        $display("Watchdog: no beat for %0d cycles", idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
      if (res_bus.valid && res_bus.ready) begin
        results_seen++;
        if (expected_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result beat: %h", res_bus.data);
        end else begin
          sfp_res_t want;
          want = expected_res.pop_front();
          if (res_bus.data.range_error) range_errors++;
          if (res_bus.data.value !== want.value ||
              res_bus.data.range_error !== want.range_error) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch at result %0d: value exp %h got %h, error exp %b got %b",
                       results_seen, want.value, res_bus.data.value,
                       want.range_error, res_bus.data.range_error);
          end
        end
      end
    end
  end

  task automatic wait_drained();
    while (cmd_queue.size() > 0 || cmd_bus.valid || expected_res.size() > 0) @(posedge clk);
  endtask

  initial begin
    logic [63:0] ones;
    ones = '1;
    cmd_bus.valid = 1'b0;
    cmd_bus.data = '0;
    res_bus.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Draws from the all-zero reset state, then extremes of every field.
    for (int s = 0; s < 4; s++) cmd_queue.push_back(make_cmd(OP_RAW, 2'(s), 0, 0, 0));
    cmd_queue.push_back(make_cmd(OP_SEED, SEL_8, 0, 0, 0));
    for (int s = 0; s < 4; s++) begin
      cmd_queue.push_back(make_cmd(OP_RANGE, 2'(s), 0, 0, ones));
      cmd_queue.push_back(make_cmd(OP_RANGE, 2'(s), 0, ones, ones));
    end
    cmd_queue.push_back(make_cmd(OP_SEED, SEL_64, ones, ones, 0));
    cmd_queue.push_back(make_cmd(OP_RANGE, SEL_64, 0, 5, 6));
    cmd_queue.push_back(make_cmd(OP_RANGE, SEL_8, 0, 64'h1_0000_0010, 64'h20));
    cmd_queue.push_back(make_cmd(OP_RANGE, SEL_16, 0, 64'h10, 64'h1_0000));
    cmd_queue.push_back(make_cmd(OP_RANGE, SEL_64, 0, 0, 1));
    cmd_queue.push_back(make_cmd(OP_UNUSED, SEL_32, ones, ones, ones));
    for (int s = 0; s < 4; s++) cmd_queue.push_back(make_cmd(OP_RAW, 2'(s), 0, 0, 0));
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 49 : 0;
      recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 9 : 0;
      for (int i = 0; i < 600; i++) cmd_queue.push_back(random_cmd());
      if (phase == 2) begin
        // Stall the receiver while the sender fills the input queue.
        hold_off_req = 1'b1;
        wait (hold_off_cycles >= 400);
        hold_off_req = 1'b0;
      end
      wait_drained();
      // Sender is held idle here, after every result is back.
      drain_wait = 1'b1;
      repeat ($urandom_range(20, 80)) @(posedge clk);
      drain_wait = 1'b0;
    end

    repeat (100) @(posedge clk);
    $display("Covered %0d commands over all widths with seeds, draws and range draws;",
             cmds_sent);
    $display("%0d results checked, %0d range errors, %0d mismatches.",
             results_seen, range_errors, mismatches);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
